/* hw/rtl/eobc_pkg.sv */
package eobc_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int COUNT_BITS = 16;
    localparam int DAY_BITS   = 32;
    localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
    localparam int OCC_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int ENTRY_BITS = COUNT_BITS + DAY_BITS;

    typedef struct packed {
        logic [15:0] new_count;
        logic [15:0] shelf_life;
    } in_item_t;

    typedef struct packed {
        logic        ate_one;
        logic [31:0] total_eaten;
        logic [10:0] batches_held;
        logic        batch_dropped;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [DAY_BITS-1:0]   expiry;
    } entry_t;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,      // latch the input item, compute expiry
        OP_PUSH_WR,    // grow the heap, pos = old occupancy
        OP_UP_RD,      // read parent of pos
        OP_UP_CMP,     // compare cur with parent, move parent down or settle cur
        OP_PUT,        // write cur at pos
        OP_TOP_RD,     // read root
        OP_POP_LAST,   // read last entry, shrink the heap
        OP_POP_LD,     // take the last entry as the one to sift down from the root
        OP_DN_RDL,     // read left child
        OP_DN_RDR,     // read right child
        OP_DN_CMP,     // pick best child, move it up or settle cur
        OP_EAT,        // decrement root count
        OP_FINISH      // form result, advance day
    } op_t;

    typedef struct packed {
        logic want_push;   // a batch arrives and there is room
        logic at_root;     // sift-up position is zero
        logic up_swap;     // sift-up moves on
        logic heap_empty;
        logic top_stale;   // root expired or empty
        logic has_left;
        logic has_right;
        logic dn_swap;     // sift-down moves on
    } status_t;

endpackage

/* hw/rtl/expiry_ordered_batch_consumer.sv */
// Channel | Signals                          | Payload
// in      | in_valid / in_ready              | eobc_pkg::in_item_t (new_count, shelf_life)
// out     | out_valid / out_ready            | eobc_pkg::out_item_t
//
// One item per day tick. The time to a result grows with each level an insert climbs, and
// each expired or empty top adds more for every level its replacement sinks.
// Reset clears occupancy, day and total; the heap memory is not cleared.
// A new item is taken only once the previous result has been taken.
module expiry_ordered_batch_consumer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  eobc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output eobc_pkg::out_item_t out_data
);

    eobc_pkg::op_t     op;
    eobc_pkg::status_t status;
    eobc_pkg::in_item_t in_hold_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_hold_reg <= in_data;
        end
    end

    eobc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .op       (op)
    );

    eobc_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .in_item(in_hold_reg),
        .status (status),
        .result (out_data)
    );

endmodule

/* hw/rtl/eobc_ram.sv */
module eobc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/eobc_datapath.sv */
module eobc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  eobc_pkg::op_t       op,
    input  eobc_pkg::in_item_t  in_item,
    output eobc_pkg::status_t   status,
    output eobc_pkg::out_item_t result
);

    localparam int AB = eobc_pkg::ADDR_BITS;
    localparam int OB = eobc_pkg::OCC_BITS;
    localparam int CB = eobc_pkg::COUNT_BITS;
    localparam int DB = eobc_pkg::DAY_BITS;
    localparam logic [DB-1:0] DAY_MAX = {DB{1'b1}};
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    logic [OB-1:0]      occ_reg;
    logic [DB-1:0]      day_reg;
    logic [31:0]        total_reg;
    logic               ate_reg, drop_reg;
    eobc_pkg::entry_t   cur_reg;     // entry being sifted
    eobc_pkg::entry_t   left_reg;
    logic [AB:0]        pos_reg;     // one bit wider for child math
    logic               cnt_nz_reg;

    logic               we;
    logic [AB-1:0]      waddr, raddr;
    eobc_pkg::entry_t   wdata, rdata;

    eobc_ram #(.WIDTH(eobc_pkg::ENTRY_BITS), .DEPTH(eobc_pkg::HEAP_DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [AB:0]   parent_idx, left_idx, right_idx;
    logic [DB:0]   exp_sum;
    logic [DB-1:0] exp_sat;
    logic [CB-1:0] cnt_sat;
    logic [OB-1:0] last_idx;
    logic          r_best;

    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign left_idx   = {pos_reg[AB-1:0], 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign exp_sum    = {1'b0, day_reg} + (DB+1)'(in_item.shelf_life);
    assign exp_sat    = exp_sum[DB] ? DAY_MAX : exp_sum[DB-1:0];
    assign cnt_sat    = (in_item.new_count > 16'(COUNT_MAX)) ? COUNT_MAX
                        : CB'(in_item.new_count);
    assign last_idx   = occ_reg - 1'b1;

    // RAM control: reads registered, data valid the cycle after a read op.
    // Sifting keeps the moving entry in cur and writes it once at its final place.
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg[AB-1:0];
        wdata = cur_reg;
        raddr = '0;
        case (op)
            eobc_pkg::OP_UP_RD:    raddr = parent_idx[AB-1:0];
            eobc_pkg::OP_UP_CMP:
            begin
                // Parent moves down into pos when cur is smaller.
                we = 1'b1;
                if (status.up_swap)
                begin
                    wdata = rdata;
                end
            end
            eobc_pkg::OP_PUT:      we = 1'b1;
            eobc_pkg::OP_POP_LAST: raddr = last_idx[AB-1:0];
            eobc_pkg::OP_DN_RDL:   raddr = left_idx[AB-1:0];
            eobc_pkg::OP_DN_RDR:   raddr = right_idx[AB-1:0];
            eobc_pkg::OP_DN_CMP:
            begin
                we = 1'b1;
                if (status.dn_swap)
                begin
                    wdata = r_best ? rdata : left_reg;
                end
            end
            eobc_pkg::OP_EAT:
            begin
                // The root read keeps address zero, so rdata still holds the root.
                we = 1'b1;
                waddr = '0;
                wdata = {rdata.count - 1'b1, rdata.expiry};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        r_best = status.has_right && rdata.expiry < cur_reg.expiry
                 && rdata.expiry < left_reg.expiry;
        status.want_push  = cnt_nz_reg && (occ_reg < OB'(eobc_pkg::HEAP_DEPTH));
        status.at_root    = pos_reg == '0;
        status.up_swap    = cur_reg.expiry < rdata.expiry;
        status.heap_empty = occ_reg == '0;
        status.top_stale  = rdata.expiry <= day_reg || rdata.count == '0;
        status.has_left   = left_idx < occ_reg;
        status.has_right  = right_idx < occ_reg;
        status.dn_swap    = (left_reg.expiry < cur_reg.expiry) || r_best;
        if (!status.has_left)
        begin
            status.dn_swap = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            day_reg    <= '0;
            total_reg  <= '0;
            ate_reg    <= 1'b0;
            drop_reg   <= 1'b0;
            cnt_nz_reg <= 1'b0;
            cur_reg    <= '0;
            left_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            case (op)
                eobc_pkg::OP_START:
                begin
                    cnt_nz_reg <= in_item.new_count != '0;
                    drop_reg   <= (in_item.new_count != '0)
                                  && (occ_reg >= OB'(eobc_pkg::HEAP_DEPTH));
                    ate_reg    <= 1'b0;
                    cur_reg    <= {cnt_sat, exp_sat};
                end
                eobc_pkg::OP_PUSH_WR:
                begin
                    occ_reg <= occ_reg + 1'b1;
                    pos_reg <= (AB+1)'(occ_reg);
                end
                eobc_pkg::OP_UP_CMP:
                begin
                    if (status.up_swap)
                    begin
                        pos_reg <= parent_idx;
                    end
                end
                eobc_pkg::OP_POP_LAST:
                begin
                    occ_reg <= last_idx;
                end
                eobc_pkg::OP_POP_LD:
                begin
                    cur_reg <= rdata;
                    pos_reg <= '0;
                end
                eobc_pkg::OP_DN_RDR:
                begin
                    left_reg <= rdata;
                end
                eobc_pkg::OP_DN_CMP:
                begin
                    if (status.dn_swap)
                    begin
                        pos_reg <= r_best ? right_idx : left_idx;
                    end
                end
                eobc_pkg::OP_EAT:
                begin
                    ate_reg <= 1'b1;
                    if (total_reg != '1)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                end
                eobc_pkg::OP_FINISH:
                begin
                    if (day_reg != DAY_MAX)
                    begin
                        day_reg <= day_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.ate_one       = ate_reg;
        result.total_eaten   = total_reg;
        result.batches_held  = 11'(occ_reg);
        result.batch_dropped = drop_reg;
    end

endmodule

/* hw/rtl/eobc_ctrl.sv */
module eobc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  eobc_pkg::status_t status,
    output eobc_pkg::op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_PUSH, S_UPRD, S_UPCMP, S_TOPRD, S_TOPCHK,
        S_LAST, S_POPLD, S_DNL, S_DNR, S_DNCMP, S_EAT, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = state_reg == S_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op = eobc_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:   if (in_valid && in_ready) state_next = S_START;
            S_START:
            begin
                op = eobc_pkg::OP_START;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (status.want_push)
                begin
                    op = eobc_pkg::OP_PUSH_WR;
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_TOPRD;
                end
            end
            S_UPRD:
            begin
                if (status.at_root)
                begin
                    op = eobc_pkg::OP_PUT;
                    state_next = S_TOPRD;
                end
                else
                begin
                    op = eobc_pkg::OP_UP_RD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                op = eobc_pkg::OP_UP_CMP;
                state_next = status.up_swap ? S_UPRD : S_TOPRD;
            end
            S_TOPRD:
            begin
                if (status.heap_empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    op = eobc_pkg::OP_TOP_RD;
                    state_next = S_TOPCHK;
                end
            end
            S_TOPCHK:
            begin
                if (status.top_stale)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    state_next = S_EAT;
                end
            end
            S_LAST:
            begin
                op = eobc_pkg::OP_POP_LAST;
                state_next = S_POPLD;
            end
            S_POPLD:
            begin
                op = eobc_pkg::OP_POP_LD;
                state_next = S_DNL;
            end
            S_DNL:
            begin
                if (status.has_left)
                begin
                    op = eobc_pkg::OP_DN_RDL;
                    state_next = S_DNR;
                end
                else
                begin
                    op = eobc_pkg::OP_PUT;
                    state_next = S_TOPRD;
                end
            end
            S_DNR:
            begin
                op = eobc_pkg::OP_DN_RDR;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                op = eobc_pkg::OP_DN_CMP;
                state_next = status.dn_swap ? S_DNL : S_TOPRD;
            end
            S_EAT:
            begin
                op = eobc_pkg::OP_EAT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                op = eobc_pkg::OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* tb/expiry_ordered_batch_consumer_test.sv */
`timescale 1ns / 1ps

class pantry_scoreboard;
    logic [15:0] shelf_count[$];
    logic [31:0] shelf_expiry[$];
    int unsigned stock_size;
    logic [31:0] today;
    logic [31:0] eaten;
    eobc_pkg::out_item_t pending_days[$];
    int unsigned failures;

    function new();
        stock_size = 0;
        today = 0;
        eaten = 0;
        failures = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
        logic [15:0] c;
        logic [31:0] e;
        c = shelf_count[a];
        e = shelf_expiry[a];
        shelf_count[a] = shelf_count[b];
        shelf_expiry[a] = shelf_expiry[b];
        shelf_count[b] = c;
        shelf_expiry[b] = e;
    endfunction

    function void settle_down();
        int unsigned pos;
        int unsigned best;
        int unsigned l;
        pos = 0;
        forever
        begin
            best = pos;
            l = 2 * pos + 1;
            if (l < stock_size && shelf_expiry[l] < shelf_expiry[best])
                best = l;
            if (l + 1 < stock_size && shelf_expiry[l + 1] < shelf_expiry[best])
                best = l + 1;
            if (best == pos)
                return;
            swap_slots(best, pos);
            pos = best;
        end
    endfunction

    // Works out one day tick and queues the result it must produce.
    function void note_day(eobc_pkg::in_item_t it);
        eobc_pkg::out_item_t r;
        logic [32:0] due;
        int unsigned pos;
        r = '0;
        if (it.new_count != 0)
        begin
            if (stock_size >= eobc_pkg::HEAP_DEPTH)
                r.batch_dropped = 1'b1;
            else
            begin
                due = {1'b0, today} + 33'(it.shelf_life);
                if (due[32])
                    due = 33'h0_FFFF_FFFF;
                pos = stock_size;
                if (shelf_count.size() <= pos)
                begin
                    shelf_count.push_back(16'd0);
                    shelf_expiry.push_back(32'd0);
                end
                shelf_count[pos] = it.new_count;
                shelf_expiry[pos] = due[31:0];
                stock_size++;
                while (pos != 0 && shelf_expiry[pos] < shelf_expiry[(pos - 1) / 2])
                begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end
        while (stock_size != 0 && (shelf_expiry[0] <= today || shelf_count[0] == 0))
        begin
            stock_size--;
            shelf_count[0] = shelf_count[stock_size];
            shelf_expiry[0] = shelf_expiry[stock_size];
            settle_down();
        end
        if (stock_size != 0)
        begin
            shelf_count[0]--;
            r.ate_one = 1'b1;
            if (eaten != 32'hFFFF_FFFF)
                eaten++;
        end
        if (today != 32'hFFFF_FFFF)
            today++;
        r.total_eaten = eaten;
        r.batches_held = stock_size[10:0];
        pending_days.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        failures++;
    endtask

    task check_day(eobc_pkg::out_item_t got);
        eobc_pkg::out_item_t want;
        if (pending_days.size() == 0)
        begin
            $display("result arrived with no item outstanding");
            failures++;
            return;
        end
        want = pending_days.pop_front();
        if (got.ate_one !== want.ate_one)
            report("ate_one", 32'(got.ate_one), 32'(want.ate_one));
        if (got.total_eaten !== want.total_eaten)
            report("total_eaten", got.total_eaten, want.total_eaten);
        if (got.batches_held !== want.batches_held)
            report("batches_held", 32'(got.batches_held), 32'(want.batches_held));
        if (got.batch_dropped !== want.batch_dropped)
            report("batch_dropped", 32'(got.batch_dropped), 32'(want.batch_dropped));
    endtask
endclass

module expiry_ordered_batch_consumer_test;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    eobc_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    eobc_pkg::out_item_t out_data;

    pantry_scoreboard pantry;
    int unsigned send_idle_pct;
    int unsigned take_idle_pct;
    bit hold_off;
    bit stimulus_done;
    longint unsigned cycle_count;

    expiry_ordered_batch_consumer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        pantry = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        hold_off = 1'b0;
        stimulus_done = 1'b0;
        cycle_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off that lets the heap stall its input.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pantry.check_day(out_data);
        out_ready <= rst_n && !hold_off && ($urandom_range(99) >= take_idle_pct);
    end

    // Offers one day tick, with random idle gaps before it.
    task automatic send_day(logic [15:0] cnt, logic [15:0] life);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{new_count: cnt, shelf_life: life};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pantry.note_day(in_data);
    endtask

    task automatic random_day();
        int unsigned pick;
        logic [15:0] cnt;
        logic [15:0] life;
        pick = $urandom_range(99);
        if (pick < 35)
            cnt = 0;
        else if (pick < 80)
            cnt = 16'($urandom_range(1, 4));
        else
            cnt = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            life = 16'($urandom_range(0, 40));
        else if (pick < 85)
            life = 16'hFFFF - 16'($urandom_range(3));
        else
            life = 16'($urandom);
        send_day(cnt, life);
    endtask

    initial
    begin
        int unsigned k;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);
        send_day(0, 0);
        send_day(1, 0);
        send_day(1, 1);
        send_day(16'hFFFF, 16'hFFFF);
        send_day(3, 5);
        send_day(2, 5);
        send_day(2, 5);
        send_day(1, 2);
        send_day(16'h5555, 16'hAAAA);
        send_day(16'hAAAA, 16'h5555);
        for (k = 0; k < 8; k++)
            send_day(0, 16'($urandom));

        send_idle_pct = 12;
        take_idle_pct = 81;
        for (k = 0; k < 250; k++)
            random_day();
        send_idle_pct = 81;
        take_idle_pct = 12;
        for (k = 0; k < 250; k++)
            random_day();
        send_idle_pct = 0;
        take_idle_pct = 0;
        // Large long-lived batches are hardly used up, so the heap fills and drops follow.
        for (k = 0; k < eobc_pkg::HEAP_DEPTH + 40; k++)
        begin
            if (k == 20)
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            send_day(16'($urandom_range(1000, 3000)), 16'hFFF0 + 16'($urandom_range(15)));
        end
        for (k = 0; k < 170; k++)
            random_day();
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        while (pantry.pending_days.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (pantry.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
